>>> rtl/dss_pkg.sv
// package for the decimal seven-segment scan driver: constants, state type, digit table
`timescale 1ns / 1ps

package dss_pkg;

  localparam int DIGIT_COUNT_DEF = 8;

  localparam int VALUE_W = 27;
  localparam int POS_W   = 3;
  localparam int BLANK_W = 4;
  localparam int BYTE_W  = 8;
  localparam int DIGIT_W = 4;

  localparam logic [BLANK_W-1:0] BLANK_RESET   = 4'd2;
  localparam logic [BYTE_W-1:0]  BLANK_PATTERN = 8'hff;
  localparam logic [BYTE_W-1:0]  TOP_SELECT    = 8'h80;

  // x / 10 == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP_TEN   = 32'hcccccccd;
  localparam int          RECIP_SHIFT = 35;
  localparam int          PROD_W      = VALUE_W + 32;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // active-low segment codes for the decimal digits
  function automatic logic [BYTE_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
    logic [BYTE_W-1:0] code;
    unique case (digit)
      4'd0:    code = 8'hc0;
      4'd1:    code = 8'hf9;
      4'd2:    code = 8'ha4;
      4'd3:    code = 8'hb0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hf8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = BLANK_PATTERN;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/decimal_seven_segment_scan.sv
// decimal seven-segment scan driver: splits a value into digit frames, one divide by ten per frame
// the first frame follows a value transfer via the state register and the output register in turn;
// after that, one frame per cycle while the sink keeps up. A value with n significant digits (n capped
//   at DIGIT_COUNT) takes n steps of the shared divide-by-ten unit; zero yields no frame. No new
// value is taken before the last frame; a step needs the output register empty or being taken
// rst is synchronous, active high: sequencer idle, no frame pending, blank position back to 2
`timescale 1ns / 1ps

module decimal_seven_segment_scan import dss_pkg::*; #(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write_en,
  input  logic [BLANK_W-1:0] cfg_write_data,
  // value channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] display_value,
  // frame channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  digit_select,
  output logic [BYTE_W-1:0]  segment_pattern,
  output logic               last_digit
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGIT_COUNT - 1);

  state_t state, state_next;

  logic [BLANK_W-1:0] blank_position;
  logic [VALUE_W-1:0] rest;       // value still to be split
  logic [POS_W-1:0]   pos;        // position of the digit being produced

  logic               in_xfer;
  logic               out_xfer;
  logic               step_en;    // shared unit produces a frame this cycle
  logic               step_last;

  // shared divide-by-ten unit
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] quot_x10;
  logic [VALUE_W-1:0] rem_wide;
  logic [DIGIT_W-1:0] digit;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  assign prod     = PROD_W'(rest) * PROD_W'(RECIP_TEN);
  assign quot     = VALUE_W'(prod >> RECIP_SHIFT);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem_wide = rest - quot_x10;
  assign digit    = rem_wide[DIGIT_W-1:0];

  // final frame once nothing is left or the last display position is reached
  assign step_last = (quot == '0) || (pos == LAST_POS);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        // a zero value produces no frames, so it never leaves idle
        if (in_xfer && (display_value != '0)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_en && step_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    step_en  = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_RUN:  step_en  = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
        step_en  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      blank_position <= BLANK_RESET;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        blank_position <= cfg_write_data;
      end
      // output register holds a frame until the sink takes it
      if (step_en) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rest <= display_value;
      pos  <= '0;
    end else if (step_en) begin
      rest <= quot;
      pos  <= pos + 1'b1;
    end
    if (step_en) begin
      digit_select <= TOP_SELECT >> pos;
      // blanked position still consumes its digit
      if ({1'b0, pos} == blank_position) begin
        segment_pattern <= BLANK_PATTERN;
      end else begin
        segment_pattern <= seg_code(digit);
      end
      last_digit <= step_last;
    end
  end

endmodule

>>> bench/tb_top.sv
// testbench for the decimal seven-segment scan driver: directed and random values checked per frame
`timescale 1ns / 1ps

module tb_top;
  import dss_pkg::*;

  // one digit frame as the display sees it
  typedef struct packed {
    logic [BYTE_W-1:0] sel;
    logic [BYTE_W-1:0] seg;
    logic              last;
  } frame_t;

  // the block is built with its default digit count
  localparam int FRAME_LIMIT = DIGIT_COUNT_DEF;
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // active-low segment bytes, indexed by decimal digit
  localparam logic [BYTE_W-1:0] SEG_OF_DIGIT [10] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write_en = 1'b0;
  logic [BLANK_W-1:0] cfg_write_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] display_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [BYTE_W-1:0]  digit_select;
  logic [BYTE_W-1:0]  segment_pattern;
  logic               last_digit;

  // frames still owed by the block, oldest first
  frame_t pending_frames[$];
  // our own copy of the blank position register
  logic [BLANK_W-1:0] blank_now = BLANK_RESET;
  // while set, neither side inserts idle cycles
  bit steady = 1'b0;
  int errors = 0;

  decimal_seven_segment_scan u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .display_value   (display_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .digit_select    (digit_select),
    .segment_pattern (segment_pattern),
    .last_digit      (last_digit)
  );

  always #10 clk = ~clk;

  // divide by ten until nothing is left or every position is used; lowest digit first
  function automatic void split_into_frames(input logic [VALUE_W-1:0] value,
                                            input logic [BLANK_W-1:0] blank);
    logic [VALUE_W-1:0] rest;
    int pos;
    frame_t f;
    rest = value;
    pos = 0;
    while (rest != 0 && pos < FRAME_LIMIT) begin
      f.sel = TOP_SELECT >> pos;
      // the blanked position still eats its digit
      f.seg = (pos == blank) ? BLANK_PATTERN : SEG_OF_DIGIT[rest % 10];
      rest = rest / 10;
      // digits above the top position are dropped, so the top frame is always last
      f.last = (rest == 0) || (pos == FRAME_LIMIT - 1);
      pending_frames.push_back(f);
      pos++;
    end
  endfunction

  // one value transfer; valid is left high afterwards, so back-to-back values can follow without a gap
  task automatic put_value(input logic [VALUE_W-1:0] value);
    while (!steady && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    display_value <= value;
    do @(posedge clk); while (!in_ready);
    // transfer happened at this edge, with the register as it stands now
    split_into_frames(value, blank_now);
  endtask

  // stop sending, let every owed frame arrive, then give a zero value time to retire
  task automatic wait_idle(input int extra);
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // register writes only ever happen with the block idle
  task automatic set_blank(input logic [BLANK_W-1:0] blank);
    wait_idle(4);
    cfg_write_en <= 1'b1;
    cfg_write_data <= blank;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    blank_now = blank;
  endtask

  // field extremes, zero, digit overflow and every digit glyph, blank at its reset position
  task automatic test_digit_extremes();
    put_value('0);              // nothing to show
    put_value(27'd1);
    put_value(27'd9);
    put_value(27'd10);          // nonzero digit above a zero one
    put_value(27'd12);          // too short to reach the blanked position
    put_value(27'd1000);        // inner zeros are not suppressed
    put_value(27'd12345678);
    put_value(27'd98765432);
    put_value(27'd99999999);    // largest eight-digit value
    put_value(27'd100000000);   // ninth digit dropped, the eight kept are all zero
    put_value(VALUE_MAX);       // every input bit high, nine digits
    put_value('0);
  endtask

  // lowest, highest, disabled and out-of-range blank positions
  task automatic test_blank_positions();
    logic [BLANK_W-1:0] picks [4] = '{4'd0, 4'd7, 4'd8, 4'd15};
    foreach (picks[i]) begin
      set_blank(picks[i]);
      put_value(27'd87654321);
      put_value(27'd5);
      put_value(VALUE_MAX - 27'($urandom_range(0, 999)));
    end
  endtask

  // random values in phases, each phase under its own blank position
  task automatic test_random_values();
    int digits;
    int lo;
    int hi;
    int kind;
    for (int phase = 0; phase < 4; phase++) begin
      set_blank(BLANK_W'($urandom_range(0, 15)));
      // one phase runs with both sides always ready
      steady = (phase == 2);
      repeat (21) begin
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
          put_value('0);
        end else if (kind == 1) begin
          put_value(VALUE_W'($urandom));
        end else if (kind == 2) begin
          // nine-digit values past the displayable range
          put_value(VALUE_W'($urandom_range(134217727, 100000000)));
        end else begin
          digits = $urandom_range(1, 8);
          lo = 1;
          for (int d = 1; d < digits; d++) lo = lo * 10;
          hi = lo * 10 - 1;
          put_value(VALUE_W'($urandom_range(hi, lo)));
        end
      end
      steady = 1'b0;
    end
  endtask

  // sink side: random back-pressure except in the steady stretch
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 29);
  end

  // every frame transfer is matched against the oldest owed frame
  always @(posedge clk) begin
    frame_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected frame: sel %h seg %h last %b",
                   digit_select, segment_pattern, last_digit);
      end else begin
        want = pending_frames.pop_front();
        if (digit_select !== want.sel || segment_pattern !== want.seg ||
            last_digit !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("frame mismatch: expected sel %h seg %h last %b, got sel %h seg %h last %b",
                     want.sel, want.seg, want.last,
                     digit_select, segment_pattern, last_digit);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_digit_extremes();
    test_blank_positions();
    test_random_values();
    // all values sent: drain, then wait on for stray frames
    wait_idle(20);
    if (errors == 0 && pending_frames.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> decimal_seven_segment_scan.f
rtl/dss_pkg.sv
rtl/decimal_seven_segment_scan.sv
bench/tb_top.sv
